// File: rtl/core/prm_pkg.sv
// Shared types and constants for the phrase run match detector.
package prm_pkg;

  localparam int unsigned CODE_COUNT = 8192;
  localparam int unsigned LETTER_W   = 13;
  localparam int unsigned ADDR_W     = $clog2(CODE_COUNT);
  localparam int unsigned CODE_EXT_W = (ADDR_W > LETTER_W) ? ADDR_W : LETTER_W;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned RUN_W      = 8;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 2 * POS_W;

  localparam logic [RUN_W-1:0] MIN_RUN_RST  = RUN_W'(8);
  localparam logic [POS_W-1:0] BASE_POS_RST = POS_W'(1);

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_LETTER = 1'b1
  } prm_cmd_e;

  typedef enum logic [0:0] {
    REG_MIN_RUN  = 1'b0,
    REG_BASE_POS = 1'b1
  } prm_reg_e;

  typedef struct packed {
    logic             wr;
    prm_reg_e         idx;
    logic [CFG_W-1:0] data;
  } prm_cfg_t;

  typedef struct packed {
    logic letter;
    logic pend;
    logic in_range;
  } prm_item_t;

endpackage

// File: rtl/core/prm_map.sv
// Presence bitmap: array with separate write and read ports and a clearing sweep after reset.
module prm_map (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [prm_pkg::ADDR_W-1:0] wr_addr_i,
  input  logic                       wr_data_i,
  input  logic                       rd_en_i,
  input  logic [prm_pkg::ADDR_W-1:0] rd_addr_i,
  output logic                       rd_data_o,
  output logic                       busy_o
);
  import prm_pkg::*;

  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(CODE_COUNT - 1);

  logic              mem [CODE_COUNT];
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              busy_q, busy_d;
  logic              rd_q;

  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + ADDR_W'(1);
      if (clr_q == LastAddr) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= 1'b0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;

endmodule

// File: rtl/core/prm_scan.sv
// Run counter, match capture, config registers and result register.
module prm_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  prm_pkg::prm_item_t        item_i,
  input  logic                      hit_i,
  input  prm_pkg::prm_cfg_t         cfg_i,
  input  logic                      out_ready_i,
  output logic                      ready_o,
  output logic                      out_valid_o,
  output logic [prm_pkg::POS_W-1:0] match_start_o,
  output logic [prm_pkg::POS_W-1:0] match_end_o
);
  import prm_pkg::*;

  logic             s1_valid_q, s1_valid_d;
  prm_item_t        s1_item_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [RUN_W-1:0] run_q, run_d;
  logic [POS_W-1:0] start_q, start_d;
  logic             started_q, started_d;
  logic             done_q, done_d;
  logic [RUN_W-1:0] min_run_q, min_run_d;
  logic             out_valid_q, out_valid_d;
  logic [POS_W-1:0] out_start_q, out_start_d;
  logic [POS_W-1:0] out_end_q, out_end_d;

  logic             out_free;
  logic             advance;
  logic [RUN_W-1:0] trig;
  logic [RUN_W-1:0] run_new;
  logic [POS_W-1:0] cfg_pos;

  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = s1_valid_q && out_free;
  assign ready_o  = !s1_valid_q || out_free;
  assign trig     = min_run_q - RUN_W'(1);
  assign run_new  = (hit_i && s1_item_q.in_range) ? run_q + RUN_W'(1) : '0;
  assign cfg_pos  = (cfg_i.data == '0) ? POS_W'(1) : cfg_i.data;

  always_comb begin
    s1_valid_d  = accept_i ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    pos_d       = pos_q;
    run_d       = run_q;
    start_d     = start_q;
    started_d   = started_q;
    done_d      = done_q;
    min_run_d   = min_run_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_start_d = out_start_q;
    out_end_d   = out_end_q;

    if (advance && s1_item_q.letter) begin
      pos_d = pos_q + POS_W'(1);
      if (s1_item_q.pend) begin
        run_d     = '0;
        start_d   = '0;
        started_d = 1'b0;
        done_d    = 1'b0;
      end else if (!done_q) begin
        run_d = run_new;
        if (run_new == trig) begin
          // start = here - trig + 1
          start_d   = pos_q + POS_W'(1) - POS_W'(trig);
          started_d = 1'b1;
        end
        if (started_d && run_new == '0) begin
          out_valid_d = 1'b1;
          out_start_d = start_d;
          out_end_d   = pos_q;
          done_d      = 1'b1;
        end
      end
    end

    if (cfg_i.wr) begin
      unique case (cfg_i.idx)
        REG_MIN_RUN:  min_run_d = cfg_i.data[RUN_W-1:0];
        REG_BASE_POS: pos_d = cfg_pos;
        default:      min_run_d = min_run_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pos_q       <= BASE_POS_RST;
      run_q       <= '0;
      start_q     <= '0;
      started_q   <= 1'b0;
      done_q      <= 1'b0;
      min_run_q   <= MIN_RUN_RST;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      pos_q       <= pos_d;
      run_q       <= run_d;
      start_q     <= start_d;
      started_q   <= started_d;
      done_q      <= done_d;
      min_run_q   <= min_run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_item_q <= item_i;
    end
    out_start_q <= out_start_d;
    out_end_q   <= out_end_d;
  end

  assign out_valid_o   = out_valid_q;
  assign match_start_o = out_start_q;
  assign match_end_o   = out_end_q;

endmodule

// File: rtl/core/phrase_run_match_detector.sv
// Top level of the phrase run match detector.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: letter_code, present_bit; tuser: command;
//                                        tlast: phrase_end
//  m_axis    out  tvalid/tready          tdata: match_start, match_end
//  cfg       in   cfg_valid/cfg_ready    cfg_index (register), cfg_data
//
// One request per cycle sustained while no result stalls and the sweep is done.
// A letter's result is registered in turn: the bitmap read is registered at
// accept, the run logic then fills the result register. After reset the bitmap is
// swept to zero, one entry per cycle over all CODE_COUNT entries; s_axis_tready
// stays low meanwhile, config writes are taken as ever. A stalled result holds
// the run stage; input keeps flowing until that stage is also full.
module phrase_run_match_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request side
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [prm_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [12:0] letter_code, [13] present_bit
  input  logic                           s_axis_tuser,  // [0] command
  input  logic                           s_axis_tlast,  // phrase_end
  // result side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [prm_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] match_start, [63:32] match_end
  // config writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [prm_pkg::CFG_W-1:0]      cfg_data_i
);
  import prm_pkg::*;

  localparam int unsigned CmpW = CODE_EXT_W + 1;

  logic [LETTER_W-1:0]   letter_code;
  logic                  present_bit;
  logic [CODE_EXT_W-1:0] code_ext;
  logic [ADDR_W-1:0]     addr;
  logic                  in_range;
  logic                  accept;
  logic                  scan_ready;
  logic                  map_busy;
  logic                  map_hit;
  logic                  is_letter;
  prm_item_t             item;
  prm_cfg_t              cfg;
  logic [POS_W-1:0]      match_start;
  logic [POS_W-1:0]      match_end;

  assign letter_code = s_axis_tdata[LETTER_W-1:0];
  assign present_bit = s_axis_tdata[LETTER_W];
  assign code_ext    = CODE_EXT_W'(letter_code);
  assign addr        = code_ext[ADDR_W-1:0];
  // codes beyond the map read as absent and ignore loads
  assign in_range    = {1'b0, code_ext} < CmpW'(CODE_COUNT);

  assign s_axis_tready = !map_busy && scan_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_letter     = (prm_cmd_e'(s_axis_tuser) == CMD_LETTER);

  assign item.letter   = is_letter;
  assign item.pend     = s_axis_tlast;
  assign item.in_range = in_range;

  // the user must ensure the block is idle during writes; the block does not enforce it, and config is always taken
  assign cfg_ready_o = 1'b1;
  assign cfg.wr      = cfg_valid_i;
  assign cfg.idx     = prm_reg_e'(cfg_index_i);
  assign cfg.data    = cfg_data_i;

  prm_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept && !is_letter && in_range),
    .wr_addr_i (addr),
    .wr_data_i (present_bit),
    .rd_en_i   (accept),
    .rd_addr_i (addr),
    .rd_data_o (map_hit),
    .busy_o    (map_busy)
  );

  prm_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (item),
    .hit_i         (map_hit),
    .cfg_i         (cfg),
    .out_ready_i   (m_axis_tready),
    .ready_o       (scan_ready),
    .out_valid_o   (m_axis_tvalid),
    .match_start_o (match_start),
    .match_end_o   (match_end)
  );

  assign m_axis_tdata = {match_end, match_start};

endmodule

// File: rtl/core/prm_checker.sv
// Port-level checks for the phrase run match detector, bound to the top level.
module prm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tuser,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [prm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import prm_pkg::*;

  // no result while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a fresh result comes from a non-closing letter taken earlier through the run stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tuser && !s_axis_tlast, 2))
    else $error("result without a scanned letter");

endmodule

bind phrase_run_match_detector prm_checker u_prm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
